// File: hw/rtl/dqta_pkg.sv
// Package with the shared types, constants and helper functions of the time adjuster.
`timescale 1ns / 1ps
`default_nettype none

package dqta_pkg;

    // Width of the per-channel wrapping step count.
    localparam int COUNT_BITS = 8;

    // Detent phase at which an accumulated count is turned into an adjustment.
    localparam logic [1:0] DETENT_PHASE = 2'd3;

    // A count in UP_LOW .. UP_LIMIT-1 adds one; a count above DOWN_ABOVE subtracts one.
    localparam int UP_LOW     = 1;
    localparam int UP_LIMIT   = 100;
    localparam int DOWN_ABOVE = 'h90;

    // Minute and hour bounds.
    localparam logic signed [6:0] MINUTE_WRAP = 7'sd60;
    localparam logic signed [6:0] MINUTE_MAX  = 7'sd59;
    localparam logic signed [6:0] HOUR_WRAP   = 7'sd24;
    localparam logic [4:0]        HOUR_MAX    = 5'd23;

    // Adjustment that one channel asks for at a detent.
    typedef enum logic [1:0] {
        ADJ_NONE = 2'd0,
        ADJ_UP   = 2'd1,
        ADJ_DOWN = 2'd2
    } adj_t;

    // One input sample: both encoder phases and the current time.
    typedef struct packed {
        logic [1:0] minute_phase;
        logic [1:0] hour_phase;
        logic [5:0] minute_in;
        logic [4:0] hour_in;
    } sample_t;

    // One result: the adjusted time.
    typedef struct packed {
        logic [5:0] minute_out;
        logic [4:0] hour_out;
    } result_t;

    // Clockwise successor of each Gray phase: 3->2, 2->0, 0->1, 1->3.
    function automatic logic [1:0] cw_next(input logic [1:0] phase);
        logic [1:0] nxt;
        case (phase)
            2'd0:    nxt = 2'd1;
            2'd1:    nxt = 2'd3;
            2'd2:    nxt = 2'd0;
            default: nxt = 2'd2;
        endcase
        return nxt;
    endfunction

    // Signed step that an adjustment applies to a value.
    function automatic logic signed [6:0] adj_value(input adj_t adj);
        logic signed [6:0] v;
        case (adj)
            ADJ_UP:   v = 7'sd1;
            ADJ_DOWN: v = -7'sd1;
            default:  v = 7'sd0;
        endcase
        return v;
    endfunction

    // Daily wrap of an hour that may have stepped one past either end.
    function automatic logic [4:0] wrap_hour(input logic signed [6:0] hour);
        logic [4:0] h;
        if (hour == HOUR_WRAP) begin
            h = 5'd0;
        end else if (hour > HOUR_WRAP || hour < 7'sd0) begin
            h = HOUR_MAX;
        end else begin
            h = hour[4:0];
        end
        return h;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dqta_lane.sv
// One encoder lane: tracks the last phase and step count and reports detent adjustments.
`timescale 1ns / 1ps
`default_nettype none

module dqta_lane #(
    parameter int COUNT_BITS = dqta_pkg::COUNT_BITS
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         advance,
    input  wire logic [1:0]   phase,
    output dqta_pkg::adj_t    adj
);

    localparam logic [COUNT_BITS-1:0] CNT_ONE   = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] CNT_LOW   = COUNT_BITS'(dqta_pkg::UP_LOW);
    localparam logic [COUNT_BITS-1:0] CNT_LIMIT = COUNT_BITS'(dqta_pkg::UP_LIMIT);
    localparam logic [COUNT_BITS-1:0] CNT_DOWN  = COUNT_BITS'(dqta_pkg::DOWN_ABOVE);

    logic [1:0]            last_phase_reg;
    logic [1:0]            last_phase_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] count_sum;

    always_comb
    begin
        // A clockwise step counts up, a counter-clockwise one counts down (wrapping).
        if (dqta_pkg::cw_next(last_phase_reg) == phase) begin
            count_sum = count_reg + CNT_ONE;
        end else if (dqta_pkg::cw_next(phase) == last_phase_reg) begin
            count_sum = count_reg - CNT_ONE;
        end else begin
            count_sum = count_reg;
        end

        adj        = dqta_pkg::ADJ_NONE;
        count_next = count_sum;
        if (phase == dqta_pkg::DETENT_PHASE) begin
            if (count_sum >= CNT_LOW && count_sum < CNT_LIMIT) begin
                adj = dqta_pkg::ADJ_UP;
            end else if (count_sum > CNT_DOWN) begin
                adj = dqta_pkg::ADJ_DOWN;
            end
            count_next = '0;
        end
        last_phase_next = phase;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            last_phase_reg <= '0;
            count_reg      <= '0;
        end else if (advance) begin
            last_phase_reg <= last_phase_next;
            count_reg      <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/dqta_merge.sv
// Merge stage: applies both lane adjustments with minute roll over and daily hour wrap.
`timescale 1ns / 1ps
`default_nettype none

module dqta_merge (
    input  wire logic [5:0]      minute_in,
    input  wire logic [4:0]      hour_in,
    input  dqta_pkg::adj_t       minute_adj,
    input  dqta_pkg::adj_t       hour_adj,
    output dqta_pkg::result_t    result
);

    logic signed [6:0] minute_sum;
    logic signed [6:0] minute_fix;
    logic signed [6:0] hour_carry;
    logic [4:0]        hour_first;
    logic signed [6:0] hour_sum;

    always_comb
    begin
        // The minute channel goes first and may carry or borrow into the hour.
        minute_sum = $signed({1'b0, minute_in}) + dqta_pkg::adj_value(minute_adj);
        if (minute_sum == dqta_pkg::MINUTE_WRAP) begin
            minute_fix = 7'sd0;
            hour_carry = $signed({2'b00, hour_in}) + 7'sd1;
        end else if (minute_sum > dqta_pkg::MINUTE_WRAP || minute_sum < 7'sd0) begin
            minute_fix = dqta_pkg::MINUTE_MAX;
            hour_carry = $signed({2'b00, hour_in}) - 7'sd1;
        end else begin
            minute_fix = minute_sum;
            hour_carry = $signed({2'b00, hour_in});
        end
        hour_first = dqta_pkg::wrap_hour(hour_carry);

        // The minute is already in range here, so only the hour moves.
        hour_sum = $signed({2'b00, hour_first}) + dqta_pkg::adj_value(hour_adj);

        result.minute_out = minute_fix[5:0];
        result.hour_out   = dqta_pkg::wrap_hour(hour_sum);
    end

endmodule

`default_nettype wire

// File: hw/rtl/dual_quadrature_time_adjuster_unit.sv
// Top level of the dual quadrature time adjuster: two encoder lanes, merge and output register.
`timescale 1ns / 1ps
`default_nettype none

// Each sample transfer carries the phases of a minute and an hour quadrature encoder together
// with the current minute and hour, and produces exactly one result transfer with the adjusted
// time. Each encoder keeps its own wrapping step count that rises on clockwise Gray steps and
// falls on counter-clockwise ones; when its phase reaches the detent value 3 a small positive
// count adds one to the value, a count above 0x90 subtracts one, and the count clears. The
// minute is handled first and carries or borrows into the hour, and the hour wraps within a
// 24-hour day. Out-of-range inputs are folded back the same way even without a step. The block
// takes one sample every cycle while the consumer keeps up: both lanes and the merge logic are
// combinational, and the result appears in the output register in the cycle after its sample
// transfer. A new sample is taken whenever that register is empty or is being emptied in the
// same cycle.

module dual_quadrature_time_adjuster_unit #(
    parameter int COUNT_BITS = dqta_pkg::COUNT_BITS
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          sample_valid,
    output logic               sample_ready,
    input  dqta_pkg::sample_t  sample,
    output logic               result_valid,
    input  wire logic          result_ready,
    output dqta_pkg::result_t  result
);

    logic               accept;
    dqta_pkg::adj_t     minute_adj;
    dqta_pkg::adj_t     hour_adj;
    dqta_pkg::result_t  merged;

    logic               result_valid_reg;
    logic               result_valid_next;
    dqta_pkg::result_t  result_reg;

    // The output register frees up in the same cycle that its result is taken.
    assign sample_ready = !result_valid_reg || result_ready;
    assign accept       = sample_valid && sample_ready;

    // Minute lane: encoder state advances only on an accepted sample.
    dqta_lane #(
        .COUNT_BITS (COUNT_BITS)
    ) u_minute_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .phase   (sample.minute_phase),
        .adj     (minute_adj)
    );

    // Hour lane.
    dqta_lane #(
        .COUNT_BITS (COUNT_BITS)
    ) u_hour_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .phase   (sample.hour_phase),
        .adj     (hour_adj)
    );

    // Combine both adjustments into the new time.
    dqta_merge u_merge (
        .minute_in  (sample.minute_in),
        .hour_in    (sample.hour_in),
        .minute_adj (minute_adj),
        .hour_adj   (hour_adj),
        .result     (merged)
    );

    always_comb
    begin
        if (accept) begin
            result_valid_next = 1'b1;
        end else if (result_ready) begin
            result_valid_next = 1'b0;
        end else begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            result_valid_reg <= 1'b0;
        end else begin
            result_valid_reg <= result_valid_next;
        end
    end

    // The payload register needs no reset; it is qualified by the valid flag.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            result_reg <= merged;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Every accepted sample leaves a result waiting in the next cycle.
    a_accept_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> result_valid
    ) else $error("accepted sample did not produce a result");

    // A result is loaded from the merge logic of the accepted sample.
    a_result_from_merge: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> result == $past(merged)
    ) else $error("result does not match the merged value of its sample");

    // The adjusted minute always lies within an hour.
    a_minute_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> result.minute_out <= 6'd59
    ) else $error("minute out of range");

    // The adjusted hour always lies within a day.
    a_hour_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> result.hour_out <= 5'd23
    ) else $error("hour out of range");

endmodule

`default_nettype wire
